FILE: rtl/pse_pkg.sv
// shared types, constants and helpers for the printable string extractor
`default_nettype none

package pse_pkg;

    localparam int HOLD_DEPTH_DEF = 16;
    localparam int CHAR_W         = 7;
    localparam int SR_W           = 5;
    localparam int PADDR_W        = 3;
    localparam int PDATA_W        = 32;

    localparam logic [7:0]         PRINT_LOW      = 8'd32;
    localparam logic [7:0]         PRINT_HIGH     = 8'd126;
    localparam logic [SR_W-1:0]    SHORTEST_RESET = 5'd4;
    localparam logic [PADDR_W-1:0] REG_SHORTEST   = 3'd0;

    localparam logic ENC_ASCII = 1'b0;
    localparam logic ENC_WIDE  = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } pse_in_t;

    typedef struct packed {
        logic              encoding;
        logic [CHAR_W-1:0] character;
        logic              string_end;
        logic              burst_last;
    } pse_out_t;

    // per-lane decision flags for one input byte
    typedef struct packed {
        logic wr_en;
        logic pass;
        logic str_end;
        logic emitting_next;
    } pse_flags_t;

    function automatic logic is_printable(input logic [7:0] b);
        return (b >= PRINT_LOW) && (b <= PRINT_HIGH);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/pse_hold_mem.sv
// held character store for both encodings, one write and one registered read port
`default_nettype none

module pse_hold_mem
    import pse_pkg::*;
#(
    parameter int HOLD_DEPTH = HOLD_DEPTH_DEF,
    localparam int AW = $clog2(HOLD_DEPTH) + 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire logic [CHAR_W-1:0] wr_data,
    input  wire logic [AW-1:0]     rd_addr,
    output logic      [CHAR_W-1:0] rd_data
);

    logic [CHAR_W-1:0] mem [2**AW];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: rtl/pse_lane_plan.sv
// per-encoding run decision: hold, flush, pass-through and close for one byte
`default_nettype none

module pse_lane_plan
    import pse_pkg::*;
#(
    parameter int HOLD_DEPTH = HOLD_DEPTH_DEF,
    localparam int CNT_W = $clog2(HOLD_DEPTH + 1),
    localparam int IDX_W = $clog2(HOLD_DEPTH)
) (
    input  wire logic             hit,
    input  wire logic             close,
    input  wire logic [CNT_W-1:0] count,
    input  wire logic             emitting,
    input  wire logic [CNT_W-1:0] thr,
    output pse_flags_t            flags,
    output logic      [IDX_W-1:0] wr_idx,
    output logic      [CNT_W-1:0] flush_len,
    output logic      [CNT_W-1:0] count_next
);

    logic [CNT_W-1:0] cnt_new;
    logic [CNT_W-1:0] count_after;
    logic             em_after;

    always_comb begin
        // saturate the write slot at the last entry
        wr_idx      = (count < CNT_W'(HOLD_DEPTH)) ? count[IDX_W-1:0] : IDX_W'(HOLD_DEPTH - 1);
        cnt_new     = CNT_W'(wr_idx) + CNT_W'(1);
        flags       = '0;
        flush_len   = '0;
        count_after = count;
        em_after    = emitting;
        if (hit) begin
            if (emitting) begin
                flags.pass = 1'b1;
            end else begin
                flags.wr_en = 1'b1;
                count_after = cnt_new;
                if (cnt_new >= thr) begin
                    flush_len = cnt_new;
                    em_after  = 1'b1;
                end
            end
        end
        flags.str_end       = close && em_after;
        flags.emitting_next = !close && em_after;
        count_next          = close ? '0 : count_after;
    end

endmodule

`default_nettype wire

FILE: rtl/printable_string_extractor.sv
// top level: run tracking, flush sequencer, output register and config register
// results of a byte come ascii lane first, then wide; per lane the flushed held characters,
//   read from the store, then a pass-through character, then an end marker
// output stalls hold the sequencer, and s_ready is high only while idle, so a new byte is
//   taken only after every result of the last one has been loaded
// reset (aresetn low, synchronous) closes all runs, restarts alignment at even, shortest_run 4
`default_nettype none

module printable_string_extractor
    import pse_pkg::*;
#(
    parameter int HOLD_DEPTH = HOLD_DEPTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // input byte stream
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire pse_in_t            s_data,
    // result stream
    output logic                    m_valid,
    input  wire logic               m_ready,
    output pse_out_t                m_data,
    // configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    localparam int CNT_W = $clog2(HOLD_DEPTH + 1);
    localparam int IDX_W = $clog2(HOLD_DEPTH);
    localparam int AW    = IDX_W + 1;
    localparam int RES_W = $clog2(2 * HOLD_DEPTH + 3);
    localparam int TW    = (CNT_W > SR_W) ? CNT_W : SR_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WWR,
        S_SEL,
        S_PUT
    } state_t;

    state_t state_reg;

    // configuration
    logic [SR_W-1:0]  sr_reg;
    logic [CNT_W-1:0] thr;

    // run state per encoding
    logic [CNT_W-1:0] a_count_reg, w_count_reg;
    logic             a_emit_reg, w_emit_reg;
    logic             odd_reg;
    logic [7:0]       pend_reg;

    // per-byte plan, indexed by lane (0 ascii, 1 wide)
    logic [CNT_W-1:0]  flush_len_reg [2];
    logic              pass_reg      [2];
    logic              end_reg       [2];
    logic [CHAR_W-1:0] pch_reg       [2];
    logic              lane_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [RES_W-1:0]  total_reg, emitted_reg;

    // deferred wide write, the store has one write port
    logic             w_wr_en_reg;
    logic [IDX_W-1:0] w_wr_idx_reg;
    logic [CHAR_W-1:0] w_wr_ch_reg;

    // output register
    logic     m_valid_reg;
    pse_out_t m_res_reg;

    // byte decode
    logic       accept;
    logic [7:0] b;
    logic       fin;
    logic       a_hit, a_close, w_hit, w_close;

    pse_flags_t       a_flags, w_flags;
    logic [IDX_W-1:0] a_wr_idx, w_wr_idx;
    logic [CNT_W-1:0] a_flush, w_flush, a_count_next, w_count_next;

    // memory ports
    logic              mem_wr_en;
    logic [AW-1:0]     mem_wr_addr;
    logic [CHAR_W-1:0] mem_wr_data;
    logic [AW-1:0]     mem_rd_addr;
    logic [CHAR_W-1:0] mem_rd_data;

    // sequencer
    logic              out_free;
    logic              sel_flush;
    logic              pass_cur, end_cur;
    logic              load_en;
    logic [CHAR_W-1:0] load_char;
    logic              load_end;
    logic              lane_done;

    // ---------------------------------------------------------------
    // configuration register
    // ---------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sr_reg <= SHORTEST_RESET;
        end else if (psel && penable && pwrite && paddr == REG_SHORTEST) begin
            sr_reg <= pwdata[SR_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == REG_SHORTEST) begin
            prdata = {{(PDATA_W - SR_W){1'b0}}, sr_reg};
        end
    end

    // zero counts as one, values above the store depth saturate
    always_comb begin
        priority if (sr_reg == '0) begin
            thr = CNT_W'(1);
        end else if (TW'(sr_reg) > TW'(HOLD_DEPTH)) begin
            thr = CNT_W'(HOLD_DEPTH);
        end else begin
            thr = CNT_W'(sr_reg);
        end
    end

    // ---------------------------------------------------------------
    // byte decode and per-lane plans
    // ---------------------------------------------------------------
    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign b       = s_data.data_byte;
    assign fin     = s_data.final_byte;

    assign a_hit   = is_printable(b);
    assign a_close = !a_hit || fin;
    // a wide character completes on the high byte of an aligned pair
    assign w_hit   = odd_reg && is_printable(pend_reg) && (b == 8'd0);
    assign w_close = (odd_reg && !w_hit) || fin;

    pse_lane_plan #(.HOLD_DEPTH(HOLD_DEPTH)) u_ascii_plan (
        .hit        (a_hit),
        .close      (a_close),
        .count      (a_count_reg),
        .emitting   (a_emit_reg),
        .thr        (thr),
        .flags      (a_flags),
        .wr_idx     (a_wr_idx),
        .flush_len  (a_flush),
        .count_next (a_count_next)
    );

    pse_lane_plan #(.HOLD_DEPTH(HOLD_DEPTH)) u_wide_plan (
        .hit        (w_hit),
        .close      (w_close),
        .count      (w_count_reg),
        .emitting   (w_emit_reg),
        .thr        (thr),
        .flags      (w_flags),
        .wr_idx     (w_wr_idx),
        .flush_len  (w_flush),
        .count_next (w_count_next)
    );

    // ---------------------------------------------------------------
    // hold store: ascii written at the transaction, wide written in the S_WWR state, later
    // ---------------------------------------------------------------
    always_comb begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = {ENC_ASCII, a_wr_idx};
        mem_wr_data = b[CHAR_W-1:0];
        if (accept && a_flags.wr_en) begin
            mem_wr_en = 1'b1;
        end else if (state_reg == S_WWR && w_wr_en_reg) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = {ENC_WIDE, w_wr_idx_reg};
            mem_wr_data = w_wr_ch_reg;
        end
    end

    assign mem_rd_addr = {lane_reg, idx_reg[IDX_W-1:0]};

    pse_hold_mem #(.HOLD_DEPTH(HOLD_DEPTH)) u_hold (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // ---------------------------------------------------------------
    // result selection
    // ---------------------------------------------------------------
    assign out_free  = !m_valid_reg || m_ready;
    assign sel_flush = idx_reg < flush_len_reg[lane_reg];
    assign pass_cur  = pass_reg[lane_reg];
    assign end_cur   = end_reg[lane_reg];
    assign lane_done = !sel_flush && !pass_cur && !end_cur;

    always_comb begin
        load_en   = 1'b0;
        load_char = '0;
        load_end  = 1'b0;
        if (state_reg == S_PUT) begin
            // read data belongs to the address held during the selection cycle
            load_en   = out_free;
            load_char = mem_rd_data;
        end else if (state_reg == S_SEL && !sel_flush && (pass_cur || end_cur)) begin
            load_en = out_free;
            if (pass_cur) begin
                load_char = pch_reg[lane_reg];
            end else begin
                load_end = 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // sequencer and run state
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            a_count_reg    <= '0;
            a_emit_reg     <= 1'b0;
            w_count_reg    <= '0;
            w_emit_reg     <= 1'b0;
            odd_reg        <= 1'b0;
            pend_reg       <= '0;
            lane_reg       <= ENC_ASCII;
            idx_reg        <= '0;
            total_reg      <= '0;
            emitted_reg    <= '0;
            w_wr_en_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
            for (int i = 0; i < 2; i++) begin
                flush_len_reg[i] <= '0;
                pass_reg[i]      <= 1'b0;
                end_reg[i]       <= 1'b0;
            end
        end else begin
            // a new load refills the output register, else a taken result empties it
            if (load_en) begin
                m_valid_reg <= 1'b1;
                emitted_reg <= emitted_reg + RES_W'(1);
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        a_count_reg <= a_count_next;
                        a_emit_reg  <= a_flags.emitting_next;
                        w_count_reg <= w_count_next;
                        w_emit_reg  <= w_flags.emitting_next;
                        // a final byte restarts alignment for the next dump
                        odd_reg     <= fin ? 1'b0 : !odd_reg;
                        if (fin) begin
                            pend_reg <= '0;
                        end else if (!odd_reg) begin
                            pend_reg <= b;
                        end
                        flush_len_reg[0] <= a_flush;
                        pass_reg[0]      <= a_flags.pass;
                        end_reg[0]       <= a_flags.str_end;
                        pch_reg[0]       <= b[CHAR_W-1:0];
                        flush_len_reg[1] <= w_flush;
                        pass_reg[1]      <= w_flags.pass;
                        end_reg[1]       <= w_flags.str_end;
                        pch_reg[1]       <= pend_reg[CHAR_W-1:0];
                        w_wr_en_reg      <= w_flags.wr_en;
                        w_wr_idx_reg     <= w_wr_idx;
                        w_wr_ch_reg      <= pend_reg[CHAR_W-1:0];
                        total_reg   <= RES_W'(a_flush) + RES_W'(a_flags.pass)
                                     + RES_W'(a_flags.str_end) + RES_W'(w_flush)
                                     + RES_W'(w_flags.pass) + RES_W'(w_flags.str_end);
                        emitted_reg <= '0;
                        lane_reg    <= ENC_ASCII;
                        idx_reg     <= '0;
                        state_reg   <= S_WWR;
                    end
                end
                S_WWR: begin
                    w_wr_en_reg <= 1'b0;
                    state_reg   <= S_SEL;
                end
                S_SEL: begin
                    priority if (sel_flush) begin
                        state_reg <= S_PUT;
                    end else if (pass_cur) begin
                        if (out_free) begin
                            pass_reg[lane_reg] <= 1'b0;
                        end
                    end else if (end_cur) begin
                        if (out_free) begin
                            end_reg[lane_reg] <= 1'b0;
                        end
                    end else if (lane_reg == ENC_ASCII) begin
                        lane_reg <= ENC_WIDE;
                        idx_reg  <= '0;
                    end else begin
                        state_reg <= S_IDLE;
                    end
                end
                S_PUT: begin
                    if (out_free) begin
                        idx_reg   <= idx_reg + CNT_W'(1);
                        state_reg <= S_SEL;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // result payload, burst_last when this is the final result of the byte
    always_ff @(posedge aclk) begin
        if (load_en) begin
            m_res_reg.encoding   <= lane_reg;
            m_res_reg.character  <= load_char;
            m_res_reg.string_end <= load_end;
            m_res_reg.burst_last <= (emitted_reg + RES_W'(1)) == total_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_res_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    a_end_no_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.string_end |-> m_data.character == '0)
        else $error("end marker carries a character");

    a_all_emitted: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SEL && lane_reg == ENC_WIDE && lane_done |-> emitted_reg == total_reg)
        else $error("byte finished with result count mismatch");

    a_put_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_PUT |-> idx_reg < flush_len_reg[lane_reg])
        else $error("flush read beyond held characters");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        a_count_reg <= CNT_W'(HOLD_DEPTH) && w_count_reg <= CNT_W'(HOLD_DEPTH))
        else $error("run count beyond store depth");

endmodule

`default_nettype wire
